@@ sv/msbbr_pkg.sv @@
// ----------------------------------------------------------------------------
// msbbr_pkg
// Shared types and command codes for the MSB-first bit reader.
// ----------------------------------------------------------------------------
package msbbr_pkg;

  localparam logic [1:0] CMD_READ_BITS = 2'd0;
  localparam logic [1:0] CMD_READ_BYTE = 2'd1;
  localparam logic [1:0] CMD_FLUSH     = 2'd2;
  // Unassigned code: no operation, the cache holds.
  localparam logic [1:0] CMD_SPARE     = 2'd3;

  // Largest bit count a single read bits command returns.
  localparam int unsigned READ_MAX = 32;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  read_count;
    logic [31:0] next_word;
  } req_t;

  typedef struct packed {
    logic [31:0] value;
    logic        word_taken;
    logic [5:0]  bits_left;
  } rsp_t;

endpackage

@@ sv/msb_first_bit_reader_top.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_reader_top
// MSB-first bit reader over a stream of words with a single-word bit cache.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload | dir
//  request | req_valid | req_stall | req     | in
//  result  | rsp_valid | rsp_stall | rsp     | out
//
//  One request in, one result out; a request can be taken every cycle while the
//  result side does not stall. A request passes through the request register,
//  then the step logic into the result register together with the cache update.
//  The cache feedback runs from the cache register through the step logic alone.
//  Reset clears the cache, the bit count and both register valids.
//  A stalled result holds; the request register fills behind it, then stalls.
// ----------------------------------------------------------------------------
module msb_first_bit_reader_top import msbbr_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int unsigned CW = $clog2(WORD_BITS+1);

  req_t                 req_q;
  logic                 req_full;
  rsp_t                 rsp_q;
  logic                 rsp_full;
  logic [WORD_BITS-1:0] cache;
  logic [CW-1:0]        count;
  logic [WORD_BITS-1:0] cache_next;
  logic [CW-1:0]        count_next;
  rsp_t                 rsp_next;
  logic                 advance;
  logic                 req_take;
  logic                 rsp_take;

  msbbr_step #(
    .WORD_BITS(WORD_BITS)
  ) u_step (
    .cache      (cache),
    .count      (count),
    .req        (req_q),
    .cache_next (cache_next),
    .count_next (count_next),
    .rsp        (rsp_next)
  );

  assign rsp_take  = rsp_full && !rsp_stall;
  assign advance   = req_full && (!rsp_full || !rsp_stall);
  assign req_stall = req_full && !advance;
  assign req_take  = req_valid && !req_stall;
  assign rsp_valid = rsp_full;
  assign rsp       = rsp_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
      rsp_full <= 1'b0;
      cache    <= '0;
      count    <= '0;
    end else begin
      if (req_take) begin
        req_full <= 1'b1;
      end else if (advance) begin
        req_full <= 1'b0;
      end
      if (advance) begin
        rsp_full <= 1'b1;
        cache    <= cache_next;
        count    <= count_next;
      end else if (rsp_take) begin
        rsp_full <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_take) begin
      req_q <= req;
    end
    if (advance) begin
      rsp_q <= rsp_next;
    end
  end

endmodule

@@ sv/msbbr_step.sv @@
// ----------------------------------------------------------------------------
// msbbr_step
// Combinational step: applies one command to the bit cache and count and
// builds the result transaction.
// ----------------------------------------------------------------------------
module msbbr_step import msbbr_pkg::*; #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic [WORD_BITS-1:0]               cache,
  input  logic [$clog2(WORD_BITS+1)-1:0]     count,
  input  req_t                               req,
  output logic [WORD_BITS-1:0]               cache_next,
  output logic [$clog2(WORD_BITS+1)-1:0]     count_next,
  output rsp_t                               rsp
);

  localparam int unsigned CW    = $clog2(WORD_BITS+1);
  localparam int unsigned LIMIT = (WORD_BITS < READ_MAX) ? WORD_BITS : READ_MAX;

  localparam logic [CW-1:0] W_C     = CW'(WORD_BITS);
  localparam logic [CW-1:0] BYTE_C  = CW'(8);

  logic [WORD_BITS-1:0] word;
  logic [6:0]           n_wide;
  logic [6:0]           n_lim;
  logic [CW-1:0]        n;
  logic [CW-1:0]        rest;
  logic [WORD_BITS-1:0] value_w;
  logic                 taken;

  // read byte intermediates
  logic [WORD_BITS-1:0] byte_cache;
  logic [CW-1:0]        byte_count;
  logic [2:0]           pad;
  logic [WORD_BITS-1:0] aligned;
  logic [CW-1:0]        aligned_count;
  logic [6:0]           left_wide;

  assign word   = WORD_BITS'(req.next_word);
  assign n_wide = {1'b0, req.read_count};
  assign n_lim  = (n_wide > 7'(LIMIT)) ? 7'(LIMIT) : n_wide;
  assign n      = CW'(n_lim);
  assign rest   = n - count;

  // Reload on a short cache; leftover bits are only padding then.
  assign byte_cache    = (count < BYTE_C) ? word : cache;
  assign byte_count    = (count < BYTE_C) ? W_C : count;
  assign pad           = byte_count[2:0];
  assign aligned       = byte_cache << pad;
  assign aligned_count = byte_count - CW'(pad);

  always_comb begin
    cache_next = cache;
    count_next = count;
    value_w    = '0;
    taken      = 1'b0;
    unique case (req.command)
      CMD_READ_BITS: begin
        if (n != '0) begin
          if (n <= count) begin
            value_w    = cache >> (W_C - n);
            cache_next = cache << n;
            count_next = count - n;
          end else begin
            // Cached bits form the high part; the rest comes from the new word.
            value_w    = (cache >> (W_C - n)) | (word >> (W_C - rest));
            cache_next = word << rest;
            count_next = W_C - rest;
            taken      = 1'b1;
          end
        end
      end
      CMD_READ_BYTE: begin
        value_w    = WORD_BITS'(aligned[WORD_BITS-1 -: 8]);
        cache_next = aligned << 8;
        count_next = aligned_count - BYTE_C;
        taken      = (count < BYTE_C);
      end
      CMD_FLUSH: begin
        cache_next = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign left_wide      = 7'(count_next);
  assign rsp.value      = 32'(value_w);
  assign rsp.word_taken = taken;
  assign rsp.bits_left  = left_wide[5:0];

endmodule

@@ verif/msbbr_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msbbr_checker
// Watches both channels of the bit reader and keeps its own copy of the bit
// cache. Every request transaction updates that copy and queues the result it
// should produce. Every result transaction is compared with the oldest queued
// result, field by field. The failure count and the number of results still
// owed go back to the testbench top.
// ----------------------------------------------------------------------------
module msbbr_checker import msbbr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   outstanding
);

  localparam int unsigned WORD = 32;

  logic [31:0] cache_copy;
  int unsigned cached_bits;
  rsp_t        owed_rsp[$];
  int          errors;
  int          owed;

  assign fail_count  = errors;
  assign outstanding = owed;

  // Advance the cache copy by one request and return the result it causes.
  function automatic rsp_t read_stream(req_t r);
    rsp_t        o;
    int unsigned n;
    int unsigned rest;
    int unsigned pad;
    o = '0;
    case (r.command)
      CMD_READ_BITS: begin
        n = 32'(r.read_count);
        if (n > READ_MAX) n = READ_MAX;
        if (n != 0) begin
          o.value = cache_copy >> (WORD - n);
          if (n <= cached_bits) begin
            cache_copy  = cache_copy << n;
            cached_bits = cached_bits - n;
          end else begin
            // cached bits form the high part, the new word supplies the rest
            rest         = n - cached_bits;
            o.value      = o.value | (r.next_word >> (WORD - rest));
            cache_copy   = r.next_word << rest;
            cached_bits  = WORD - rest;
            o.word_taken = 1'b1;
          end
        end
      end
      CMD_READ_BYTE: begin
        if (cached_bits < 8) begin
          cache_copy   = r.next_word;
          cached_bits  = WORD;
          o.word_taken = 1'b1;
        end
        // drop padding up to the byte boundary
        pad         = cached_bits & 7;
        cache_copy  = cache_copy << pad;
        cached_bits = cached_bits - pad;
        o.value     = {24'd0, cache_copy[31:24]};
        cache_copy  = cache_copy << 8;
        cached_bits = cached_bits - 8;
      end
      CMD_FLUSH: begin
        cache_copy  = '0;
        cached_bits = 0;
      end
      default: ;
    endcase
    o.bits_left = cached_bits[5:0];
    return o;
  endfunction

  initial begin
    errors      = 0;
    owed        = 0;
    cache_copy  = '0;
    cached_bits = 0;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      cache_copy  = '0;
      cached_bits = 0;
      owed_rsp.delete();
      owed = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (owed_rsp.size() == 0) begin
          $error("result transaction with none outstanding: %h", rsp);
          errors++;
        end else begin
          want = owed_rsp.pop_front();
          if (rsp.value !== want.value) begin
            $error("value: expected %h, actual %h", want.value, rsp.value);
            errors++;
          end
          if (rsp.word_taken !== want.word_taken) begin
            $error("word_taken: expected %0d, actual %0d", want.word_taken,
                   rsp.word_taken);
            errors++;
          end
          if (rsp.bits_left !== want.bits_left) begin
            $error("bits_left: expected %0d, actual %0d", want.bits_left,
                   rsp.bits_left);
            errors++;
          end
        end
      end
      if (req_valid && !req_stall) owed_rsp.push_back(read_stream(req));
      owed = owed_rsp.size();
    end
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the MSB-first bit reader. A directed opening walks
// the cache through its boundary cases, then random commands follow, mostly
// reads with random words. Both sides idle at random, with a calm stretch and
// one long result hold-off that backs the block up into its request side.
// ----------------------------------------------------------------------------
module tb;
  import msbbr_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int QUIET_FROM   = 300;
  localparam int QUIET_TO     = 450;
  localparam int HOLD_AT      = 600;
  localparam int HOLD_CYCLES  = 60;
  localparam int IDLE_LIMIT   = 2000;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  int   fail_count;
  int   outstanding;
  logic quiet;
  logic hold_go;
  int   idle_cycles;

  msb_first_bit_reader_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  msbbr_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic req_t make_req(logic [1:0] cmd, logic [5:0] count,
                                    logic [31:0] word);
    req_t r;
    r.command    = cmd;
    r.read_count = count;
    r.next_word  = word;
    return r;
  endfunction

  function automatic req_t random_req();
    int unsigned pick;
    logic [5:0]  count;
    pick = $urandom_range(99);
    if ($urandom_range(19) == 0) count = 6'($urandom_range(63));
    else                         count = 6'($urandom_range(32, 1));
    if (pick < 62)      return make_req(CMD_READ_BITS, count, $urandom());
    else if (pick < 88) return make_req(CMD_READ_BYTE, 6'($urandom), $urandom());
    else if (pick < 96) return make_req(CMD_FLUSH, 6'($urandom), $urandom());
    else                return make_req(CMD_SPARE, 6'($urandom), $urandom());
  endfunction

  // Offer one request transaction; called and returns at a falling edge.
  task automatic offer(req_t item);
    int gap;
    if (!quiet && $urandom_range(99) < 9) begin
      gap       = $urandom_range(4, 1);
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid = 1'b1;
    req       = item;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Result side: random stalls, none in the calm stretch, one long hold.
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        rsp_stall = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_stall = !quiet && ($urandom_range(99) < 9);
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
    else                                                       idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    req_t opening[$];
    idle_cycles = 0;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    quiet       = 1'b0;
    hold_go     = 1'b0;

    opening.push_back(make_req(CMD_READ_BYTE, 6'd0,  32'hA5C3_0FF1)); // empty cache
    opening.push_back(make_req(CMD_READ_BITS, 6'd32, 32'hAAAA_AAAA)); // take whole word
    opening.push_back(make_req(CMD_READ_BITS, 6'd1,  32'hFFFF_FFFF));
    opening.push_back(make_req(CMD_READ_BITS, 6'd0,  32'h1234_5678)); // zero count
    opening.push_back(make_req(CMD_READ_BITS, 6'd3,  32'h0000_0000));
    opening.push_back(make_req(CMD_READ_BYTE, 6'd63, 32'h0000_0000)); // pad drop
    opening.push_back(make_req(CMD_READ_BITS, 6'd63, 32'h1234_5678)); // saturate
    opening.push_back(make_req(CMD_READ_BITS, 6'd33, 32'h0000_0000));
    opening.push_back(make_req(CMD_SPARE,     6'd17, 32'hFFFF_FFFF)); // unused code
    opening.push_back(make_req(CMD_READ_BITS, 6'd32, 32'hFFFF_FFFF));
    opening.push_back(make_req(CMD_FLUSH,     6'd63, 32'hFFFF_FFFF));
    opening.push_back(make_req(CMD_READ_BITS, 6'd8,  32'hDEAD_BEEF));
    opening.push_back(make_req(CMD_READ_BITS, 6'd24, 32'h0000_0000)); // exactly cached
    opening.push_back(make_req(CMD_READ_BITS, 6'd31, 32'h8000_0001));
    opening.push_back(make_req(CMD_READ_BYTE, 6'd0,  32'hFEDC_BA98)); // few cached
    opening.push_back(make_req(CMD_READ_BITS, 6'd16, 32'h0000_0000));
    opening.push_back(make_req(CMD_READ_BYTE, 6'd0,  32'h5555_5555)); // exactly 8
    opening.push_back(make_req(CMD_READ_BYTE, 6'd0,  32'h0F0F_0F0F));
    opening.push_back(make_req(CMD_READ_BITS, 6'd5,  32'h0000_0000));
    opening.push_back(make_req(CMD_READ_BYTE, 6'd0,  32'h0000_0000));
    opening.push_back(make_req(CMD_FLUSH,     6'd0,  32'h0000_0000));
    opening.push_back(make_req(CMD_READ_BITS, 6'd32, 32'h0000_0000));
    opening.push_back(make_req(CMD_SPARE,     6'd42, 32'hAAAA_5555));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (opening[i]) offer(opening[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= QUIET_FROM) && (i < QUIET_TO);
      if (i == HOLD_AT) hold_go = 1'b1;
      offer(random_req());
    end
    quiet     = 1'b0;
    req_valid = 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else                 $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
sv/msbbr_pkg.sv
sv/msbbr_step.sv
sv/msb_first_bit_reader_top.sv
verif/msbbr_checker.sv
verif/tb.sv
